>>> design/lcpm_pkg.sv
// ----------------------------------------------------------------------------
// lcpm_pkg: shared definitions for the line centroid PID motor mixer
// Register indexes, reset values, sensor weights, multiplier widths and the
// control bundle that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package lcpm_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int SENSOR_COUNT = 8;
  localparam int GAIN_W       = 16;
  localparam int TARGET_W     = 11;
  localparam int BASE_W       = 7;
  localparam int DUTY_W       = 7;
  localparam int POS_W        = 11;
  localparam int SUM_W        = 32;

  localparam int OPND_W = 32;
  localparam int PROD_W = GAIN_W + 1 + OPND_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE   = 3'd4;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST = 16'd6400;
  localparam logic [GAIN_W-1:0]   GAIN_I_RST = 16'd0;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST = 16'd3840;
  localparam logic [TARGET_W-1:0] TARGET_RST = 11'd0;
  localparam logic [BASE_W-1:0]   BASE_RST   = 7'd50;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  localparam logic signed [3:0] SENSOR_WEIGHT [SENSOR_COUNT] =
    '{-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd1, 4'sd2, 4'sd3};

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

>>> design/lcpm_div.sv
// ----------------------------------------------------------------------------
// lcpm_div: serial restoring divider
// Divides an unsigned dividend by a small unsigned divisor, one quotient bit
// per cycle, and flags the end with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module lcpm_div #(
  parameter int FRACTION_BITS = lcpm_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [FRACTION_BITS+2:0]   dividend_i,
  input  logic [3:0]                 divisor_i,
  output logic                       done_o,
  output logic [FRACTION_BITS+2:0]   quot_o
);

  localparam int QW   = FRACTION_BITS + 3;
  localparam int CNTW = $clog2(QW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [3:0]      rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [3:0]      dvs_q, dvs_d;
  logic [4:0]      rem_shift;
  logic [4:0]      diff;
  logic            fits;

  assign rem_shift = {rem_q, quo_q[QW-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};
  assign fits      = (rem_shift >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[3:0] : rem_shift[3:0];
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> design/lcpm_mac.sv
// ----------------------------------------------------------------------------
// lcpm_mac: shared multiply-accumulate unit
// Multiplies an unsigned gain by a signed operand into a product register and
// adds the registered product into a signed accumulator on request.
// ----------------------------------------------------------------------------
module lcpm_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lcpm_pkg::mac_ctrl_t                    ctrl_i,
  input  logic [lcpm_pkg::GAIN_W-1:0]            gain_i,
  input  logic signed [lcpm_pkg::OPND_W-1:0]     opnd_i,
  output logic signed [lcpm_pkg::ACC_W-1:0]      acc_o
);

  logic signed [lcpm_pkg::PROD_W-1:0] prod_q;
  logic signed [lcpm_pkg::ACC_W-1:0]  acc_q;
  logic signed [lcpm_pkg::GAIN_W:0]   gain_s;

  assign gain_s = $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= gain_s * opnd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + {{(lcpm_pkg::ACC_W - lcpm_pkg::PROD_W){prod_q[lcpm_pkg::PROD_W-1]}},
                        prod_q};
    end
  end

  assign acc_o = acc_q;

endmodule

>>> design/line_centroid_pid_motor_mixer.sv
// ----------------------------------------------------------------------------
// line_centroid_pid_motor_mixer: line sensor centroid, PID and motor mixer
// Finds the weighted centroid of the active-low line sensors, runs one PID
// step on it and mixes the correction into left and right motor duties.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   sensor_bits_i
//   out      output     out_valid_o/out_stall_i left_duty_o, right_duty_o,
//                                               line_lost_o, line_position_o
//   config   input      APB (psel..pready)      gain_p, gain_i, gain_d,
//                                               target_centroid, nominal_duty
//
// An item runs from its transfer through the serial divider, which gives one
// quotient bit per cycle, and then through the shared multiplier, which forms
// the P, I and D terms in turn. A new item is taken only after the result has
// been loaded into the output register. A lost line skips both.
// Reset returns the sequencer to idle, clears the integral and last error and
// loads the register defaults. A stalled result stays in the output register.
// ----------------------------------------------------------------------------
module line_centroid_pid_motor_mixer #(
  parameter int FRACTION_BITS = lcpm_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        sensor_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lcpm_pkg::DUTY_W-1:0]       left_duty_o,
  output logic [lcpm_pkg::DUTY_W-1:0]       right_duty_o,
  output logic                              line_lost_o,
  output logic signed [lcpm_pkg::POS_W-1:0] line_position_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int QW   = FRACTION_BITS + 3;
  localparam int CW   = FRACTION_BITS + 4;
  localparam int TW   = lcpm_pkg::TARGET_W;
  localparam int EW   = ((CW > TW) ? CW : TW) + 1;
  localparam int DW   = EW + 1;
  localparam int PS   = 8 + FRACTION_BITS;
  localparam int SW   = lcpm_pkg::ACC_W + 1;
  localparam int OW   = lcpm_pkg::OPND_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_ERR  = 7'b0000100,
    S_PID  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DUTY = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  function automatic logic [lcpm_pkg::DUTY_W-1:0] clamp_duty(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] whole;
    whole = s >>> PS;
    if (s <= 0) begin
      clamp_duty = '0;
    end else if (whole > SW'(lcpm_pkg::DUTY_MAX)) begin
      clamp_duty = lcpm_pkg::DUTY_MAX;
    end else begin
      clamp_duty = whole[lcpm_pkg::DUTY_W-1:0];
    end
  endfunction

  state_e state_q, state_d;

  logic [lcpm_pkg::GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic signed [TW-1:0]          target_q;
  logic [lcpm_pkg::BASE_W-1:0]   base_q;
  logic                          cfg_wr;
  logic [lcpm_pkg::REG_IDX_W-1:0] cfg_idx;

  logic signed [lcpm_pkg::SUM_W-1:0] esum_q, esum_d;
  logic signed [EW-1:0]              last_q, last_d;
  logic [1:0]                        cnt_q, cnt_d;
  logic                              out_valid_q, out_valid_d;

  logic signed [3:0]     ws_c;
  logic [3:0]            seen_c;
  logic [2:0]            mag_c;
  logic                  accept;
  logic                  lost_c;

  logic                  lost_q, neg_q;
  logic signed [CW-1:0]  cent_q;
  logic signed [EW-1:0]  err_q;
  logic signed [DW-1:0]  deriv_q;
  logic signed [SW-1:0]  lsum_q, rsum_q;
  logic [lcpm_pkg::DUTY_W-1:0]       left_q, right_q;
  logic                              lost_out_q;
  logic signed [lcpm_pkg::POS_W-1:0] pos_q;

  logic                  div_start, div_done;
  logic [QW-1:0]         dividend, quot;
  logic signed [CW-1:0]  cent_mag;
  logic signed [EW-1:0]  cent_ext;
  logic signed [EW-1:0]  err_c;
  logic signed [lcpm_pkg::SUM_W:0] esum_wide;
  logic signed [DW-1:0]  deriv_c;

  lcpm_pkg::mac_ctrl_t                mac_ctrl;
  logic [lcpm_pkg::GAIN_W-1:0]        mac_gain;
  logic signed [OW-1:0]               mac_opnd;
  logic signed [lcpm_pkg::ACC_W-1:0]  mac_acc;
  logic signed [SW-1:0]               base_scaled;
  logic signed [SW-1:0]               acc_ext;
  logic                               load_out;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= lcpm_pkg::GAIN_P_RST;
      gain_i_q <= lcpm_pkg::GAIN_I_RST;
      gain_d_q <= lcpm_pkg::GAIN_D_RST;
      target_q <= lcpm_pkg::TARGET_RST;
      base_q   <= lcpm_pkg::BASE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lcpm_pkg::REG_GAIN_P: gain_p_q <= pwdata[lcpm_pkg::GAIN_W-1:0];
        lcpm_pkg::REG_GAIN_I: gain_i_q <= pwdata[lcpm_pkg::GAIN_W-1:0];
        lcpm_pkg::REG_GAIN_D: gain_d_q <= pwdata[lcpm_pkg::GAIN_W-1:0];
        lcpm_pkg::REG_TARGET: target_q <= pwdata[TW-1:0];
        lcpm_pkg::REG_BASE:   base_q   <= pwdata[lcpm_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lcpm_pkg::REG_GAIN_P: prdata = {16'd0, gain_p_q};
      lcpm_pkg::REG_GAIN_I: prdata = {16'd0, gain_i_q};
      lcpm_pkg::REG_GAIN_D: prdata = {16'd0, gain_d_q};
      lcpm_pkg::REG_TARGET: prdata = {{(32 - TW){target_q[TW-1]}}, target_q};
      lcpm_pkg::REG_BASE:   prdata = {25'd0, base_q};
      default:              prdata = '0;
    endcase
  end

  // Sensor weight sum and count.
  always_comb begin
    ws_c   = '0;
    seen_c = '0;
    for (int i = 0; i < lcpm_pkg::SENSOR_COUNT; i++) begin
      if (!sensor_bits_i[i]) begin
        ws_c   = ws_c + lcpm_pkg::SENSOR_WEIGHT[i];
        seen_c = seen_c + 4'd1;
      end
    end
  end

  assign lost_c    = (seen_c == 4'd0);
  assign mag_c     = ws_c[3] ? 3'(-ws_c) : ws_c[2:0];
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign div_start = accept && !lost_c;
  assign dividend  = {mag_c, {FRACTION_BITS{1'b0}}};

  lcpm_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (seen_c),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // PID arithmetic around the divider result.
  assign cent_mag  = $signed({1'b0, quot});
  assign cent_ext  = {{(EW - CW){cent_q[CW-1]}}, cent_q};
  assign err_c     = cent_ext - {{(EW - TW){target_q[TW-1]}}, target_q};
  assign esum_wide = {esum_q[lcpm_pkg::SUM_W-1], esum_q}
                   + {{(lcpm_pkg::SUM_W + 1 - EW){err_q[EW-1]}}, err_q};
  assign deriv_c   = {err_q[EW-1], err_q} - {last_q[EW-1], last_q};

  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        mac_gain = gain_p_q;
        mac_opnd = {{(OW - EW){err_q[EW-1]}}, err_q};
      end
      2'd1: begin
        mac_gain = gain_i_q;
        mac_opnd = esum_q;
      end
      2'd2: begin
        mac_gain = gain_d_q;
        mac_opnd = {{(OW - DW){deriv_q[DW-1]}}, deriv_q};
      end
      default: begin
        mac_gain = gain_d_q;
        mac_opnd = {{(OW - DW){deriv_q[DW-1]}}, deriv_q};
      end
    endcase
  end

  assign mac_ctrl.clr    = accept;
  assign mac_ctrl.mul_en = (state_q == S_MUL) && (cnt_q != 2'd3);
  assign mac_ctrl.acc_en = (state_q == S_MUL) && (cnt_q != 2'd0);

  lcpm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .gain_i (mac_gain),
    .opnd_i (mac_opnd),
    .acc_o  (mac_acc)
  );

  assign base_scaled = $signed(SW'(base_q) << PS);
  assign acc_ext     = {{(SW - lcpm_pkg::ACC_W){mac_acc[lcpm_pkg::ACC_W-1]}}, mac_acc};
  assign load_out    = (state_q == S_OUT) && !(out_valid_q && out_stall_i);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    esum_d      = esum_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = lost_c ? S_DUTY : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        state_d = S_PID;
      end
      S_PID: begin
        if (esum_wide[lcpm_pkg::SUM_W] != esum_wide[lcpm_pkg::SUM_W-1]) begin
          esum_d = esum_wide[lcpm_pkg::SUM_W] ? {1'b1, {(lcpm_pkg::SUM_W - 1){1'b0}}}
                                              : {1'b0, {(lcpm_pkg::SUM_W - 1){1'b1}}};
        end else begin
          esum_d = esum_wide[lcpm_pkg::SUM_W-1:0];
        end
        last_d  = err_q;
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_DUTY;
        end
      end
      S_DUTY: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      esum_q      <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      esum_q      <= esum_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lost_q <= lost_c;
      neg_q  <= ws_c[3];
      cent_q <= '0;
    end
    if ((state_q == S_DIV) && div_done) begin
      cent_q <= neg_q ? -cent_mag : cent_mag;
    end
    if (state_q == S_ERR) begin
      err_q <= err_c;
    end
    if (state_q == S_PID) begin
      deriv_q <= deriv_c;
    end
    if (state_q == S_DUTY) begin
      lsum_q <= base_scaled + acc_ext;
      rsum_q <= base_scaled - acc_ext;
    end
    if (load_out) begin
      left_q     <= clamp_duty(lsum_q);
      right_q    <= clamp_duty(rsum_q);
      lost_out_q <= lost_q;
      pos_q      <= cent_ext[lcpm_pkg::POS_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_duty_o     = left_q;
  assign right_duty_o    = right_q;
  assign line_lost_o     = lost_out_q;
  assign line_position_o = pos_q;

  // Checks.
  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result appeared outside the final sequencer step");

  a_lost_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_lost_o) |-> (left_duty_o == right_duty_o && line_position_o == '0))
    else $error("lost line result carries a correction or a position");

  a_div_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished while the sequencer was not waiting for it");

  a_accept_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (mac_acc == '0))
    else $error("accumulator not cleared at the start of an item");

endmodule
